/* rtl/olid_pkg.sv */
// Shared types and constants for the ordered list insert/delete core.
`default_nettype none

package olid_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 8;
  localparam int OUT_IDX_W    = 4;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_DUMP     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_WRITE,
    S_SCAN
  } state_e;

  typedef struct packed {
    logic                 valid;
    status_e              status;
    logic [VALUE_W-1:0]   value;
    logic [OUT_IDX_W-1:0] index;
    logic                 last;
  } res_t;

endpackage

`default_nettype wire

/* rtl/ordered_list_insert_delete_core.sv */
// Ordered list core: an insert moves the entries from its slot on up one slot
// in S_INS_SHIFT, then writes the value in S_INS_WRITE; full and empty lists are
// answered from S_IDLE. Delete and dump scan all N entries in S_SCAN, a dump
// giving one result each; requests are taken only in S_IDLE (single read port).
// Results are registered and strobed for one cycle; the receiver cannot stall.
// Reset empties the list at once; no clearing pass over the store.
`default_nettype none

module ordered_list_insert_delete_core
  import olid_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int IW      = $clog2(CAPACITY)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                opcode_i,
  input  wire logic signed [VALUE_W-1:0] item_value_i,
  input  wire logic [POS_W-1:0]          position_i,
  output logic                           result_strobe_o,
  output logic [2:0]                     status_o,
  output logic signed [VALUE_W-1:0]      out_value_o,
  output logic [OUT_IDX_W-1:0]           out_index_o,
  output logic                           last_of_run_o
);

  res_t               res;
  logic               res_valid_q;
  res_t               res_q;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [IW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  olid_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .opcode_i    (opcode_i),
    .value_i     (item_value_i),
    .position_i  (position_i),
    .busy_o      (busy),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  olid_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res;
  end

  assign result_strobe_o = res_valid_q;
  assign status_o        = res_q.status;
  assign out_value_o     = res_q.value;
  assign out_index_o     = res_q.index;
  assign last_of_run_o   = res_q.last;

endmodule

`default_nettype wire

/* rtl/olid_mem.sv */
// Entry store: one write port, one registered read port.
`default_nettype none

module olid_mem
  import olid_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int IW      = $clog2(CAPACITY)
) (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [IW-1:0]      waddr_i,
  input  wire logic [VALUE_W-1:0] wdata_i,
  input  wire logic               re_i,
  input  wire logic [IW-1:0]      raddr_i,
  output logic      [VALUE_W-1:0] rdata_o
);

  logic [VALUE_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/olid_seq.sv */
// Operation sequencer: walks the entry store for insert, delete and dump.
`default_nettype none

module olid_seq
  import olid_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int IW      = $clog2(CAPACITY),
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [VALUE_W-1:0] value_i,
  input  wire logic [POS_W-1:0]   position_i,
  output logic                    busy_o,
  output res_t                    res_o,
  output logic                    mem_we_o,
  output logic      [IW-1:0]      mem_waddr_o,
  output logic      [VALUE_W-1:0] mem_wdata_o,
  output logic                    mem_re_o,
  output logic      [IW-1:0]      mem_raddr_o,
  input  wire logic [VALUE_W-1:0] mem_rdata_i
);

  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [1:0]         op_q, op_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic [IW-1:0]      at_q, at_d;
  logic [IW-1:0]      rd_idx_q, rd_idx_d;
  logic               found_q, found_d;
  logic [IW-1:0]      hit_q, hit_d;

  logic [POS_W-1:0]   pos_at;
  logic [POS_W-1:0]   pos_clamped;
  logic               scan_last;

  // 0 or 1 selects the front, anything past the end appends
  always_comb begin
    pos_at      = (position_i <= POS_W'(1)) ? '0 : position_i - POS_W'(1);
    pos_clamped = (pos_at > POS_W'(count_q)) ? POS_W'(count_q) : pos_at;
  end

  assign scan_last = (CW'(rd_idx_q) == count_q - CW'(1));
  assign busy_o    = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    op_d        = op_q;
    val_d       = val_q;
    at_d        = at_q;
    rd_idx_d    = rd_idx_q;
    found_d     = found_q;
    hit_d       = hit_q;
    res_o       = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d    = opcode_i;
          val_d   = value_i;
          found_d = 1'b0;
          hit_d   = '0;
          case (opcode_e'(opcode_i))
            OP_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                res_o.valid  = 1'b1;
                res_o.status = STAT_FULL;
                res_o.last   = 1'b1;
              end else begin
                at_d = IW'(pos_clamped);
                if (pos_clamped == POS_W'(count_q)) begin
                  state_d = S_INS_WRITE;
                end else begin
                  // move the tail up one slot, starting at the back
                  mem_re_o    = 1'b1;
                  mem_raddr_o = IW'(count_q - CW'(1));
                  rd_idx_d    = IW'(count_q - CW'(1));
                  state_d     = S_INS_SHIFT;
                end
              end
            end
            OP_DELETE, OP_DUMP: begin
              if (count_q == '0) begin
                res_o.valid  = 1'b1;
                res_o.status = STAT_EMPTY;
                res_o.last   = 1'b1;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                rd_idx_d    = '0;
                state_d     = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_INS_SHIFT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = rd_idx_q + IW'(1);
        mem_wdata_o = mem_rdata_i;
        if (rd_idx_q == at_q) begin
          state_d = S_INS_WRITE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = rd_idx_q - IW'(1);
          rd_idx_d    = rd_idx_q - IW'(1);
        end
      end

      S_INS_WRITE: begin
        mem_we_o     = 1'b1;
        mem_waddr_o  = at_q;
        mem_wdata_o  = val_q;
        count_d      = count_q + CW'(1);
        res_o.valid  = 1'b1;
        res_o.status = STAT_OK;
        res_o.index  = OUT_IDX_W'(at_q);
        res_o.last   = 1'b1;
        state_d      = S_IDLE;
      end

      S_SCAN: begin
        if (!scan_last) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = rd_idx_q + IW'(1);
          rd_idx_d    = rd_idx_q + IW'(1);
        end else begin
          state_d = S_IDLE;
        end
        if (op_q == OP_DUMP) begin
          res_o.valid  = 1'b1;
          res_o.status = STAT_DUMP;
          res_o.value  = mem_rdata_i;
          res_o.index  = OUT_IDX_W'(rd_idx_q);
          res_o.last   = scan_last;
        end else begin
          // entries after the first match close up behind it
          if (found_q) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = rd_idx_q - IW'(1);
            mem_wdata_o = mem_rdata_i;
          end else if (mem_rdata_i == val_q) begin
            found_d = 1'b1;
            hit_d   = rd_idx_q;
          end
          if (scan_last) begin
            res_o.valid = 1'b1;
            res_o.last  = 1'b1;
            if (found_d) begin
              res_o.status = STAT_OK;
              res_o.index  = OUT_IDX_W'(hit_d);
              count_d      = count_q - CW'(1);
            end else begin
              res_o.status = STAT_NOTFOUND;
            end
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    val_q    <= val_d;
    at_q     <= at_d;
    rd_idx_q <= rd_idx_d;
    found_q  <= found_d;
    hit_q    <= hit_d;
  end

endmodule

`default_nettype wire

/* rtl/olid_chk.sv */
// Port-level checker for the ordered list core, bound to the top level.
`default_nettype none

module olid_chk
  import olid_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               result_strobe_o,
  input wire logic [2:0]         status_o,
  input wire logic [VALUE_W-1:0] out_value_o,
  input wire logic [OUT_IDX_W-1:0] out_index_o,
  input wire logic               last_of_run_o
);

  // a result only follows a request or a running operation
  a_res_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(busy || start))
    else $error("result without a request");

  // every operation that goes busy ends with its final result
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (result_strobe_o && last_of_run_o))
    else $error("operation ended without a final result");

  // only dump entries carry a value or come without the last mark
  a_nondump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && status_o != STAT_DUMP) |-> (out_value_o == '0 && last_of_run_o))
    else $error("non-dump result malformed");

  a_fail_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && (status_o == STAT_FULL || status_o == STAT_EMPTY ||
                         status_o == STAT_NOTFOUND)) |-> (out_index_o == '0))
    else $error("failed request reports an index");

endmodule

bind ordered_list_insert_delete_core olid_chk u_olid_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .result_strobe_o (result_strobe_o),
  .status_o        (status_o),
  .out_value_o     (out_value_o),
  .out_index_o     (out_index_o),
  .last_of_run_o   (last_of_run_o)
);

`default_nettype wire
